@@ sv/multichannel_conv_clamp_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel convolution block
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_CONV_CLAMP_ASSERT_SVH
`define MULTICHANNEL_CONV_CLAMP_ASSERT_SVH

// Plain property, disabled while reset is low
`define MCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must hold in every cycle the given strobe is high
`define MCC_ASSERT_ON(label, clk, rst_n, strobe, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (strobe) |-> (cond)) \
        else $error(msg);

`endif

@@ sv/mcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, constants and helpers of the multichannel convolution block.
// ----------------------------------------------------------------------------
package mcc_pkg;

    // Default sizing of the stores
    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_HEIGHT   = 64;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_KERNEL   = 8;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int ADDR_W     = 14;
    localparam int DATA_W     = 16;
    localparam int POS_W      = 6;
    localparam int VALUE_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Config register widths and reset values
    localparam int KSIZE_W  = 4;
    localparam int IMGW_W   = 7;
    localparam int IMGH_W   = 7;
    localparam int CHAN_W   = 3;
    localparam logic [KSIZE_W-1:0] KSIZE_RST = 4'd5;
    localparam logic [IMGW_W-1:0]  IMGW_RST  = 7'd60;
    localparam logic [IMGH_W-1:0]  IMGH_RST  = 7'd60;
    localparam logic [CHAN_W-1:0]  CHAN_RST  = 3'd3;

    // Arithmetic: Q1.14 operands, Q3.28 products, 40-bit accumulator
    localparam int FRAC_W = 14;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = 40;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_ONE = 40'sd268435456;
    localparam logic [VALUE_W-1:0]      VALUE_ONE = 15'd16384;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_TAP    = 2'd0,
        OP_LOAD_SAMPLE = 2'd1,
        OP_COMPUTE     = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_SIZE   = 2'd0,
        CFG_IMAGE_WIDTH   = 2'd1,
        CFG_IMAGE_HEIGHT  = 2'd2,
        CFG_CHANNEL_COUNT = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Control that travels with the read data into the MAC
    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } t_mac_ctl;

    // Register value as used: zero acts as 1, above the limit acts as the limit
    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
        int unsigned r;
        if (v < 1) begin
            r = 1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ sv/mcc_mac.sv @@
// ----------------------------------------------------------------------------
// mcc_mac
// Multiply, saturating accumulate and [0,1] clamp of the convolution sum.
// ----------------------------------------------------------------------------
module mcc_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mcc_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [mcc_pkg::DATA_W-1:0]   i_sample,
    input  logic signed [mcc_pkg::DATA_W-1:0]   i_tap,
    output logic                                o_done,
    output logic [mcc_pkg::VALUE_W-1:0]         o_value
);

    localparam int AW = mcc_pkg::ACC_W;
    localparam int FW = mcc_pkg::FRAC_W;

    logic signed [mcc_pkg::PROD_W-1:0] r_prod;
    logic                              r_pv;
    logic                              r_plast;
    logic                              r_done;
    logic signed [AW-1:0]              r_acc;
    logic signed [AW:0]                sum;
    logic signed [AW-1:0]              n_acc;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_tap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_pv    <= i_ctl.valid;
            r_plast <= i_ctl.valid & i_ctl.last;
            r_done  <= r_pv & r_plast;
        end
    end

    // accumulate, saturating after every add
    always_comb begin
        sum = (AW+1)'(r_acc) + (AW+1)'(r_prod);
        if (sum[AW] != sum[AW-1]) begin
            n_acc = sum[AW] ? mcc_pkg::ACC_MIN : mcc_pkg::ACC_MAX;
        end else begin
            n_acc = sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= n_acc;
        end
    end

    // clamp to [0, 1.0] and drop to Q1.14
    always_comb begin
        if (r_acc[AW-1]) begin
            o_value = '0;
        end else if (r_acc > mcc_pkg::ACC_ONE) begin
            o_value = mcc_pkg::VALUE_ONE;
        end else begin
            o_value = r_acc[2*FW:FW];
        end
    end

    assign o_done = r_done;

endmodule

@@ sv/multichannel_conv_clamp.sv @@
// ----------------------------------------------------------------------------
// multichannel_conv_clamp
// Valid multichannel 2-D convolution with a shared square filter and a
// [0,1] clamp, on samples and taps held in on-chip memories.
// ----------------------------------------------------------------------------
// Tap and sample loads give no result. A compute word whose window leaves
// the image is answered in the cycle after it is taken, with zero and the
// out-of-range flag, and busy stays low. Any other compute word holds busy
// while the C*K*K products (C channels, K filter side) are summed, one
// multiply-accumulate per cycle paced by the single read port of the sample
// memory; the result strobe comes in the first cycle with busy low. The
// receiver cannot stall: o_valid is high for exactly one cycle per result.
// Configuration is taken whenever busy is low. Both memories power up
// undefined and are not cleared; only entries that were loaded may be read.
module multichannel_conv_clamp #(
    parameter int MAX_WIDTH    = mcc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = mcc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = mcc_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL   = mcc_pkg::DEF_MAX_KERNEL
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command word
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [mcc_pkg::OPCODE_W-1:0]          i_opcode,
    input  logic [mcc_pkg::ADDR_W-1:0]            i_address,
    input  logic signed [mcc_pkg::DATA_W-1:0]     i_data_value,
    input  logic [mcc_pkg::POS_W-1:0]             i_pos_x,
    input  logic [mcc_pkg::POS_W-1:0]             i_pos_y,
    // result word
    output logic                                  o_valid,
    output logic [mcc_pkg::VALUE_W-1:0]           o_conv_value,
    output logic                                  o_out_of_range,
    // configuration write
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mcc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int SAMPLE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int TAP_DEPTH    = MAX_KERNEL * MAX_KERNEL;
    localparam int SA_W = $clog2(SAMPLE_DEPTH);
    localparam int TA_W = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
    localparam int K_W  = $clog2(MAX_KERNEL + 1);
    localparam int WD_W = $clog2(MAX_WIDTH + 1);
    localparam int HT_W = $clog2(MAX_HEIGHT + 1);
    localparam int C_W  = $clog2(MAX_CHANNELS + 1);
    localparam int DW   = mcc_pkg::DATA_W;

    // config registers (raw bits)
    logic [mcc_pkg::KSIZE_W-1:0] r_cfg_k;
    logic [mcc_pkg::IMGW_W-1:0]  r_cfg_w;
    logic [mcc_pkg::IMGH_W-1:0]  r_cfg_h;
    logic [mcc_pkg::CHAN_W-1:0]  r_cfg_c;

    // memories
    logic [DW-1:0] sample_mem [SAMPLE_DEPTH];
    logic [DW-1:0] tap_mem    [TAP_DEPTH];
    logic [DW-1:0] r_sample_q;
    logic [DW-1:0] r_tap_q;

    // control
    mcc_pkg::t_state r_state, n_state;
    logic [K_W-1:0]  r_k;
    logic [WD_W-1:0] r_w;
    logic [HT_W-1:0] r_h;
    logic [C_W-1:0]  r_c;
    logic [mcc_pkg::POS_W-1:0] r_px, r_py;
    logic [K_W-1:0]  r_m, n_m, r_n, n_n;
    logic [C_W-1:0]  r_d, n_d;
    logic [SA_W-1:0] r_addr, n_addr;
    logic [SA_W-1:0] r_row_base, n_row_base;
    logic [SA_W-1:0] r_plane_base, n_plane_base;
    logic [SA_W-1:0] r_win, n_win;
    logic [SA_W-1:0] r_plane_size, n_plane_size;
    logic [TA_W-1:0] r_tap_addr, n_tap_addr;
    logic            r_rd_v, r_rd_last;
    logic            r_out_valid, n_out_valid;
    logic [mcc_pkg::VALUE_W-1:0] r_conv_value, n_conv_value;
    logic            r_out_of_range, n_out_of_range;

    logic            accept;
    logic            op_compute;
    logic            win_bad;
    logic            issue, last_issue, mac_clear;
    logic            m_end, n_end, d_end;
    logic [K_W-1:0]  k_eff;
    logic [WD_W-1:0] w_eff;
    logic [HT_W-1:0] h_eff;
    logic [C_W-1:0]  c_eff;
    logic [31:0]     x_end, y_end;
    logic            tap_we, sample_we;
    logic            mac_done;
    logic [mcc_pkg::VALUE_W-1:0] mac_value;
    mcc_pkg::t_mac_ctl mac_ctl;

    assign accept     = i_start && (r_state == mcc_pkg::ST_IDLE);
    assign op_compute = (i_opcode == mcc_pkg::OP_COMPUTE);
    assign o_busy     = (r_state != mcc_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == mcc_pkg::ST_IDLE);

    // effective geometry from the raw registers
    assign k_eff = K_W'(mcc_pkg::clamp_cfg(32'(r_cfg_k), MAX_KERNEL));
    assign w_eff = WD_W'(mcc_pkg::clamp_cfg(32'(r_cfg_w), MAX_WIDTH));
    assign h_eff = HT_W'(mcc_pkg::clamp_cfg(32'(r_cfg_h), MAX_HEIGHT));
    assign c_eff = C_W'(mcc_pkg::clamp_cfg(32'(r_cfg_c), MAX_CHANNELS));

    // window bound check
    assign x_end   = 32'(i_pos_x) + 32'(k_eff);
    assign y_end   = 32'(i_pos_y) + 32'(k_eff);
    assign win_bad = (x_end > 32'(w_eff)) || (y_end > 32'(h_eff));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_k <= mcc_pkg::KSIZE_RST;
            r_cfg_w <= mcc_pkg::IMGW_RST;
            r_cfg_h <= mcc_pkg::IMGH_RST;
            r_cfg_c <= mcc_pkg::CHAN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (mcc_pkg::t_cfg_index'(i_cfg_index))
                mcc_pkg::CFG_KERNEL_SIZE:   r_cfg_k <= i_cfg_data[mcc_pkg::KSIZE_W-1:0];
                mcc_pkg::CFG_IMAGE_WIDTH:   r_cfg_w <= i_cfg_data[mcc_pkg::IMGW_W-1:0];
                mcc_pkg::CFG_IMAGE_HEIGHT:  r_cfg_h <= i_cfg_data[mcc_pkg::IMGH_W-1:0];
                mcc_pkg::CFG_CHANNEL_COUNT: r_cfg_c <= i_cfg_data[mcc_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // loads beyond a store are dropped
    assign tap_we    = accept && (i_opcode == mcc_pkg::OP_LOAD_TAP)
                       && (32'(i_address) < 32'(TAP_DEPTH));
    assign sample_we = accept && (i_opcode == mcc_pkg::OP_LOAD_SAMPLE)
                       && (32'(i_address) < 32'(SAMPLE_DEPTH));

    // tap memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (tap_we) begin
            tap_mem[TA_W'(i_address)] <= i_data_value;
        end
        r_tap_q <= tap_mem[r_tap_addr];
    end

    // sample memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (sample_we) begin
            sample_mem[SA_W'(i_address)] <= i_data_value;
        end
        r_sample_q <= sample_mem[r_addr];
    end

    // window walk: column, then row, then channel
    assign m_end = (r_m == r_k - K_W'(1));
    assign n_end = (r_n == r_k - K_W'(1));
    assign d_end = (r_d == r_c - C_W'(1));

    always_comb begin
        n_state        = r_state;
        n_m            = r_m;
        n_n            = r_n;
        n_d            = r_d;
        n_addr         = r_addr;
        n_row_base     = r_row_base;
        n_plane_base   = r_plane_base;
        n_win          = r_win;
        n_plane_size   = r_plane_size;
        n_tap_addr     = r_tap_addr;
        n_out_valid    = 1'b0;
        n_conv_value   = r_conv_value;
        n_out_of_range = r_out_of_range;
        issue          = 1'b0;
        last_issue     = 1'b0;
        mac_clear      = 1'b0;
        case (r_state)
            mcc_pkg::ST_IDLE: begin
                if (accept && op_compute) begin
                    if (win_bad) begin
                        n_out_valid    = 1'b1;
                        n_conv_value   = '0;
                        n_out_of_range = 1'b1;
                    end else begin
                        n_state = mcc_pkg::ST_SETUP;
                    end
                end
            end
            mcc_pkg::ST_SETUP: begin
                n_win        = SA_W'(32'(r_py) * 32'(r_w)) + SA_W'(r_px);
                n_row_base   = n_win;
                n_addr       = n_win;
                n_plane_base = '0;
                n_plane_size = SA_W'(32'(r_w) * 32'(r_h));
                n_m          = '0;
                n_n          = '0;
                n_d          = '0;
                n_tap_addr   = '0;
                mac_clear    = 1'b1;
                n_state      = mcc_pkg::ST_RUN;
            end
            mcc_pkg::ST_RUN: begin
                issue = 1'b1;
                if (!m_end) begin
                    n_m        = r_m + K_W'(1);
                    n_addr     = r_addr + SA_W'(1);
                    n_tap_addr = r_tap_addr + TA_W'(1);
                end else if (!n_end) begin
                    n_m        = '0;
                    n_n        = r_n + K_W'(1);
                    n_row_base = r_row_base + SA_W'(r_w);
                    n_addr     = n_row_base;
                    n_tap_addr = r_tap_addr + TA_W'(1);
                end else if (!d_end) begin
                    n_m          = '0;
                    n_n          = '0;
                    n_d          = r_d + C_W'(1);
                    n_plane_base = r_plane_base + r_plane_size;
                    n_row_base   = n_plane_base + r_win;
                    n_addr       = n_row_base;
                    n_tap_addr   = '0;
                end else begin
                    last_issue = 1'b1;
                    n_state    = mcc_pkg::ST_DRAIN;
                end
            end
            mcc_pkg::ST_DRAIN: begin
                if (mac_done) begin
                    n_out_valid    = 1'b1;
                    n_conv_value   = mac_value;
                    n_out_of_range = 1'b0;
                    n_state        = mcc_pkg::ST_IDLE;
                end
            end
            default: n_state = mcc_pkg::ST_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcc_pkg::ST_IDLE;
            r_rd_v      <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_v      <= issue;
            r_rd_last   <= last_issue;
            r_out_valid <= n_out_valid;
        end
    end

    // address walk and result payload
    always_ff @(posedge i_clk) begin
        r_m            <= n_m;
        r_n            <= n_n;
        r_d            <= n_d;
        r_addr         <= n_addr;
        r_row_base     <= n_row_base;
        r_plane_base   <= n_plane_base;
        r_win          <= n_win;
        r_plane_size   <= n_plane_size;
        r_tap_addr     <= n_tap_addr;
        r_conv_value   <= n_conv_value;
        r_out_of_range <= n_out_of_range;
    end

    // geometry captured with the compute word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_k  <= k_eff;
            r_w  <= w_eff;
            r_h  <= h_eff;
            r_c  <= c_eff;
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
    end

    // multiply-accumulate
    assign mac_ctl.clear = mac_clear;
    assign mac_ctl.valid = r_rd_v;
    assign mac_ctl.last  = r_rd_last;

    mcc_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample ($signed(r_sample_q)),
        .i_tap    ($signed(r_tap_q)),
        .o_done   (mac_done),
        .o_value  (mac_value)
    );

    assign o_valid        = r_out_valid;
    assign o_conv_value   = r_conv_value;
    assign o_out_of_range = r_out_of_range;

endmodule

@@ sv/mcc_assert_chk.sv @@
// ----------------------------------------------------------------------------
// mcc_assert_chk
// Port-level checks of the multichannel convolution block, bound to the top.
// ----------------------------------------------------------------------------
`include "multichannel_conv_clamp_assert.svh"

module mcc_assert_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic [mcc_pkg::OPCODE_W-1:0]  i_opcode,
    input logic                          o_valid,
    input logic [mcc_pkg::VALUE_W-1:0]   o_conv_value,
    input logic                          o_out_of_range
);

    // a flagged window always reads zero
    `MCC_ASSERT_ON(a_oor_zero, i_clk, i_rst_n, o_valid && o_out_of_range, o_conv_value == '0, "out-of-range word with nonzero value")

    // clamped value never exceeds 1.0
    `MCC_ASSERT_ON(a_value_max, i_clk, i_rst_n, o_valid, o_conv_value <= mcc_pkg::VALUE_ONE, "value above 1.0")

    // a load or an unused opcode starts no work and gives no word
    `MCC_ASSERT(a_load_quiet, i_clk, i_rst_n, (i_start && !o_busy && i_opcode != mcc_pkg::OP_COMPUTE) |=> (!o_busy && !o_valid), "load word caused activity")

    // every finished computation delivers its word as busy drops
    `MCC_ASSERT(a_done_word, i_clk, i_rst_n, ($fell(o_busy) && $past(i_rst_n)) |-> o_valid, "busy fell without a result")

endmodule

bind multichannel_conv_clamp mcc_assert_chk u_mcc_assert_chk (.*);

@@ tb/sv/multichannel_conv_clamp_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_conv_clamp_tb
// Self-checking bench for the multichannel convolution block. Command words
// load taps and samples and request outputs. A local predictor holds its own
// copy of both memories and of the size registers and computes the clamped
// sum of each accepted compute word; every result strobe is checked against
// the oldest prediction. Loads always cover a window before it is computed.
// ----------------------------------------------------------------------------
module multichannel_conv_clamp_tb;

    localparam int TAP_DEPTH    = mcc_pkg::DEF_MAX_KERNEL * mcc_pkg::DEF_MAX_KERNEL;
    localparam int SAMPLE_DEPTH = mcc_pkg::DEF_MAX_WIDTH * mcc_pkg::DEF_MAX_HEIGHT
                                  * mcc_pkg::DEF_MAX_CHANNELS;
    localparam int DRAIN_CYCLES = mcc_pkg::DEF_MAX_CHANNELS * TAP_DEPTH + 8;
    localparam logic [mcc_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam longint SUM_MAX = (longint'(1) <<< 39) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< 39);
    localparam longint SUM_ONE = longint'(1) <<< 28;

    typedef struct packed {
        logic [mcc_pkg::OPCODE_W-1:0] op;
        logic [mcc_pkg::ADDR_W-1:0]   addr;
        logic [mcc_pkg::DATA_W-1:0]   data;
        logic [mcc_pkg::POS_W-1:0]    px;
        logic [mcc_pkg::POS_W-1:0]    py;
    } t_conv_word;

    typedef struct packed {
        logic [mcc_pkg::VALUE_W-1:0] value;
        logic                        oor;
    } t_conv_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_start;
    logic                           o_busy;
    logic [mcc_pkg::OPCODE_W-1:0]   i_opcode;
    logic [mcc_pkg::ADDR_W-1:0]     i_address;
    logic signed [mcc_pkg::DATA_W-1:0] i_data_value;
    logic [mcc_pkg::POS_W-1:0]      i_pos_x;
    logic [mcc_pkg::POS_W-1:0]      i_pos_y;
    logic                           o_valid;
    logic [mcc_pkg::VALUE_W-1:0]    o_conv_value;
    logic                           o_out_of_range;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [mcc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mcc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state: memory images, which entries hold data, size registers
    logic [mcc_pkg::DATA_W-1:0]  tap_mem    [TAP_DEPTH];
    logic [mcc_pkg::DATA_W-1:0]  sample_mem [SAMPLE_DEPTH];
    bit                          tap_known    [TAP_DEPTH];
    bit                          sample_known [SAMPLE_DEPTH];
    logic [mcc_pkg::KSIZE_W-1:0] cfg_kernel   = mcc_pkg::KSIZE_RST;
    logic [mcc_pkg::IMGW_W-1:0]  cfg_width    = mcc_pkg::IMGW_RST;
    logic [mcc_pkg::IMGH_W-1:0]  cfg_height   = mcc_pkg::IMGH_RST;
    logic [mcc_pkg::CHAN_W-1:0]  cfg_channels = mcc_pkg::CHAN_RST;

    t_conv_result pending_conv_q[$];
    int           mismatch_count = 0;
    int           idle_pct       = 27;

    multichannel_conv_clamp DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_data_value   (i_data_value),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_valid        (o_valid),
        .o_conv_value   (o_conv_value),
        .o_out_of_range (o_out_of_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("%0t: run timed out", $time);
        $display("Simulation FAILED");
        $finish;
    end

    // Sizes as the block uses them: zero acts as 1, oversize acts as the maximum
    function automatic void get_dims(output int unsigned k, output int unsigned w,
                                     output int unsigned h, output int unsigned c);
        k = (cfg_kernel == 0) ? 1 :
            (cfg_kernel > mcc_pkg::DEF_MAX_KERNEL) ? mcc_pkg::DEF_MAX_KERNEL : cfg_kernel;
        w = (cfg_width == 0) ? 1 :
            (cfg_width > mcc_pkg::DEF_MAX_WIDTH) ? mcc_pkg::DEF_MAX_WIDTH : cfg_width;
        h = (cfg_height == 0) ? 1 :
            (cfg_height > mcc_pkg::DEF_MAX_HEIGHT) ? mcc_pkg::DEF_MAX_HEIGHT : cfg_height;
        c = (cfg_channels == 0) ? 1 :
            (cfg_channels > mcc_pkg::DEF_MAX_CHANNELS) ? mcc_pkg::DEF_MAX_CHANNELS
                                                       : cfg_channels;
    endfunction

    // Clamped multichannel sum at one window position
    function automatic t_conv_result predict_conv(logic [mcc_pkg::POS_W-1:0] px,
                                                  logic [mcc_pkg::POS_W-1:0] py);
        int unsigned  k, w, h, c, si;
        longint       acc, s, t;
        t_conv_result r;
        get_dims(k, w, h, c);
        acc = 0;
        r   = '0;
        if (px + k > w || py + k > h) begin
            r.oor = 1'b1;
            return r;
        end
        for (int unsigned d = 0; d < c; d++) begin
            for (int unsigned n = 0; n < k; n++) begin
                for (int unsigned m = 0; m < k; m++) begin
                    si  = d * w * h + (py + n) * w + (px + m);
                    s   = $signed(sample_mem[si]);
                    t   = $signed(tap_mem[n * k + m]);
                    acc = acc + s * t;
                    if (acc > SUM_MAX) acc = SUM_MAX;
                    if (acc < SUM_MIN) acc = SUM_MIN;
                end
            end
        end
        // negative -> 0, above 1.0 -> 1.0, else drop 14 fraction bits
        if (acc < 0) begin
            r.value = '0;
        end else if (acc > SUM_ONE) begin
            r.value = mcc_pkg::VALUE_ONE;
        end else begin
            r.value = mcc_pkg::VALUE_W'(acc >>> mcc_pkg::FRAC_W);
        end
        return r;
    endfunction

    // Update the memory images, or queue the expected output
    function automatic void apply_word(t_conv_word word);
        case (word.op)
            mcc_pkg::OP_LOAD_TAP: begin
                if (word.addr < TAP_DEPTH) begin
                    tap_mem[word.addr]   = word.data;
                    tap_known[word.addr] = 1'b1;
                end
            end
            mcc_pkg::OP_LOAD_SAMPLE: begin
                if (word.addr < SAMPLE_DEPTH) begin
                    sample_mem[word.addr]   = word.data;
                    sample_known[word.addr] = 1'b1;
                end
            end
            mcc_pkg::OP_COMPUTE: begin
                pending_conv_q.push_back(predict_conv(word.px, word.py));
            end
            default: begin
            end
        endcase
    endfunction

    // Q1.14 value, scaled down by an arithmetic shift
    function automatic logic [mcc_pkg::DATA_W-1:0] rand_q14(int unsigned shift);
        logic signed [mcc_pkg::DATA_W-1:0] v;
        v = mcc_pkg::DATA_W'($urandom);
        return v >>> shift;
    endfunction

    // One command word: random idle, then hold start until busy is low at an edge
    task automatic send_word(t_conv_word word);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_opcode     <= word.op;
        i_address    <= word.addr;
        i_data_value <= word.data;
        i_pos_x      <= word.px;
        i_pos_y      <= word.py;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        apply_word(word);
    endtask

    task automatic send_load(logic [mcc_pkg::OPCODE_W-1:0] op, int unsigned addr,
                             logic [mcc_pkg::DATA_W-1:0] data);
        t_conv_word word;
        word.op   = op;
        word.addr = mcc_pkg::ADDR_W'(addr);
        word.data = data;
        word.px   = mcc_pkg::POS_W'($urandom);
        word.py   = mcc_pkg::POS_W'($urandom);
        send_word(word);
    endtask

    // Load every tap and sample of the window that holds no data yet
    task automatic prime_window(logic [mcc_pkg::POS_W-1:0] px, logic [mcc_pkg::POS_W-1:0] py);
        int unsigned k, w, h, c, si, shift;
        get_dims(k, w, h, c);
        shift = $urandom_range(0, 7);
        for (int unsigned ti = 0; ti < k * k; ti++) begin
            if (!tap_known[ti]) send_load(mcc_pkg::OP_LOAD_TAP, ti, rand_q14(shift));
        end
        for (int unsigned d = 0; d < c; d++) begin
            for (int unsigned n = 0; n < k; n++) begin
                for (int unsigned m = 0; m < k; m++) begin
                    si = d * w * h + (py + n) * w + (px + m);
                    if (!sample_known[si]) begin
                        send_load(mcc_pkg::OP_LOAD_SAMPLE, si, rand_q14(shift));
                    end
                end
            end
        end
    endtask

    // Compute word; an in-range window is made fully loaded first
    task automatic compute_word(logic [mcc_pkg::POS_W-1:0] px, logic [mcc_pkg::POS_W-1:0] py);
        int unsigned k, w, h, c;
        t_conv_word  word;
        get_dims(k, w, h, c);
        if (px + k <= w && py + k <= h) prime_window(px, py);
        word.op   = mcc_pkg::OP_COMPUTE;
        word.addr = mcc_pkg::ADDR_W'($urandom);
        word.data = mcc_pkg::DATA_W'($urandom);
        word.px   = px;
        word.py   = py;
        send_word(word);
    endtask

    // Hold off until every output is back and the block has settled
    task automatic wait_block_idle();
        i_start <= 1'b0;
        while (pending_conv_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Write all four size registers with random gaps, only while idle
    task automatic write_settings(logic [mcc_pkg::CFG_DATA_W-1:0] k,
                                  logic [mcc_pkg::CFG_DATA_W-1:0] w,
                                  logic [mcc_pkg::CFG_DATA_W-1:0] h,
                                  logic [mcc_pkg::CFG_DATA_W-1:0] c);
        logic [mcc_pkg::CFG_DATA_W-1:0] vals [4];
        wait_block_idle();
        vals = '{k, w, h, c};
        for (int i = 0; i < 4; i++) begin
            while ($urandom_range(0, 99) < idle_pct) begin
                i_cfg_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_cfg_valid <= 1'b1;
            i_cfg_index <= mcc_pkg::t_cfg_index'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (mcc_pkg::t_cfg_index'(i))
                mcc_pkg::CFG_KERNEL_SIZE:   cfg_kernel   = vals[i][mcc_pkg::KSIZE_W-1:0];
                mcc_pkg::CFG_IMAGE_WIDTH:   cfg_width    = vals[i][mcc_pkg::IMGW_W-1:0];
                mcc_pkg::CFG_IMAGE_HEIGHT:  cfg_height   = vals[i][mcc_pkg::IMGH_W-1:0];
                mcc_pkg::CFG_CHANNEL_COUNT: cfg_channels = vals[i][mcc_pkg::CHAN_W-1:0];
                default: begin
                end
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random mix: mostly full windows near the origin, plus off-image computes,
    // loads and unused opcodes
    task automatic random_items(int steps);
        int          done;
        int          r;
        int unsigned k, w, h, c, si, xr, yr;
        t_conv_word  word;
        done = 0;
        while (done < steps) begin
            get_dims(k, w, h, c);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if (w >= k && h >= k) begin
                    // occasionally rewrite one tap and one sample of the plane first
                    if ($urandom_range(0, 2) == 0) begin
                        send_load(mcc_pkg::OP_LOAD_TAP, $urandom_range(0, k * k - 1),
                                  rand_q14($urandom_range(0, 7)));
                        si = $urandom_range(0, c - 1) * w * h + $urandom_range(0, h - 1) * w
                             + $urandom_range(0, w - 1);
                        send_load(mcc_pkg::OP_LOAD_SAMPLE, si, rand_q14($urandom_range(0, 7)));
                    end
                    // small offsets keep the loaded area, and the word count, small
                    xr = (w - k > 1) ? 1 : w - k;
                    yr = (h - k > 1) ? 1 : h - k;
                    compute_word(mcc_pkg::POS_W'($urandom_range(0, xr)),
                                 mcc_pkg::POS_W'($urandom_range(0, yr)));
                end else begin
                    compute_word(mcc_pkg::POS_W'($urandom), mcc_pkg::POS_W'($urandom));
                end
                done++;
            end else if (r < 62) begin
                // window off the right or bottom edge where the sizes allow one
                if (k > w || k > h) begin
                    compute_word(mcc_pkg::POS_W'($urandom), mcc_pkg::POS_W'($urandom));
                end else if (w - k < 63) begin
                    compute_word(mcc_pkg::POS_W'($urandom_range(w - k + 1, 63)),
                                 mcc_pkg::POS_W'($urandom));
                end else if (h - k < 63) begin
                    compute_word(mcc_pkg::POS_W'($urandom),
                                 mcc_pkg::POS_W'($urandom_range(h - k + 1, 63)));
                end else begin
                    compute_word(mcc_pkg::POS_W'($urandom), mcc_pkg::POS_W'($urandom));
                end
                done++;
            end else if (r < 74) begin
                send_load(mcc_pkg::OP_LOAD_TAP,
                          ($urandom_range(0, 9) == 0) ? mcc_pkg::ADDR_W'($urandom)
                                                       : $urandom_range(0, TAP_DEPTH - 1),
                          rand_q14($urandom_range(0, 7)));
                done++;
            end else if (r < 92) begin
                send_load(mcc_pkg::OP_LOAD_SAMPLE,
                          $urandom_range(0, 1) ? $urandom_range(0, c * w * h - 1)
                                               : mcc_pkg::ADDR_W'($urandom),
                          rand_q14($urandom_range(0, 7)));
                done++;
            end else begin
                word      = t_conv_word'({$urandom, $urandom});
                word.op   = OP_UNUSED;
                send_word(word);
            end
        end
    endtask

    // Tests ------------------------------------------------------------------

    task automatic test_reset_defaults();
        random_items(12);
    endtask

    // 1x1 filter on a 4x4 plane: exact 1.0, clamps both ways, lsb, ignored words
    task automatic test_clamp_corners();
        t_conv_word word;
        write_settings(7'd1, 7'd4, 7'd4, 7'd1);
        send_load(mcc_pkg::OP_LOAD_TAP, 0, 16'h4000);
        send_load(mcc_pkg::OP_LOAD_SAMPLE, 0, 16'h4000);
        compute_word(6'd0, 6'd0);
        send_load(mcc_pkg::OP_LOAD_SAMPLE, 1, 16'h8000);
        compute_word(6'd1, 6'd0);
        send_load(mcc_pkg::OP_LOAD_TAP, 0, 16'h8000);
        compute_word(6'd1, 6'd0);
        send_load(mcc_pkg::OP_LOAD_TAP, 0, 16'h7FFF);
        send_load(mcc_pkg::OP_LOAD_SAMPLE, 2, 16'h7FFF);
        compute_word(6'd2, 6'd0);
        send_load(mcc_pkg::OP_LOAD_SAMPLE, 3, 16'h0001);
        compute_word(6'd3, 6'd0);
        send_load(mcc_pkg::OP_LOAD_SAMPLE, 5, 16'h2000);
        compute_word(6'd1, 6'd1);
        send_load(mcc_pkg::OP_LOAD_SAMPLE, 5, 16'h0000);
        compute_word(6'd1, 6'd1);
        // windows off the right and bottom edges
        compute_word(6'd4, 6'd0);
        compute_word(6'd0, 6'd63);
        // unused opcode and loads past the tap memory leave state alone
        word = '{op: OP_UNUSED, addr: 14'h3FFF, data: 16'hFFFF, px: 6'h3F, py: 6'h3F};
        send_word(word);
        send_load(mcc_pkg::OP_LOAD_TAP, 64, 16'h0000);
        send_load(mcc_pkg::OP_LOAD_TAP, 16383, 16'h0000);
        send_load(mcc_pkg::OP_LOAD_SAMPLE, 16383, 16'hFFFF);
        compute_word(6'd3, 6'd0);
    endtask

    // All registers zero: everything acts as size 1
    task automatic test_register_floor();
        write_settings(7'd0, 7'd0, 7'd0, 7'd0);
        random_items(30);
    endtask

    // Oversize values saturate at the maxima
    task automatic test_register_ceiling();
        // filter side past the maximum on a 9x9 plane
        write_settings(7'd15, 7'd9, 7'd9, 7'd1);
        random_items(6);
        // width, height and channel count past their maxima
        write_settings(7'd2, 7'd127, 7'd100, 7'd7);
        random_items(6);
    endtask

    // Largest filter exactly filling an 8x8 image, two channels
    task automatic test_exact_fit();
        write_settings(7'd8, 7'd8, 7'd8, 7'd2);
        random_items(10);
    endtask

    // Random small sizes; upper data bits beyond a register are dropped
    task automatic test_mixed_sizes();
        repeat (3) begin
            write_settings({3'($urandom), 4'($urandom_range(0, 4))},
                           7'($urandom_range(0, 24)), 7'($urandom_range(0, 24)),
                           {4'($urandom), 3'($urandom_range(0, 7))});
            random_items(12);
        end
    endtask

    // Start held high with no gaps
    task automatic test_back_to_back();
        write_settings(7'd2, 7'd6, 7'd5, 7'd3);
        idle_pct = 0;
        random_items(40);
        idle_pct = 27;
    endtask

    // Result checker: the receiver never stalls, so every strobe is a word
    always @(posedge i_clk) begin
        t_conv_result want;
        if (i_rst_n && o_valid) begin
            if (pending_conv_q.size() == 0) begin
                $display("%0t: result with nothing pending: expected none, actual %0d/%0b",
                         $time, o_conv_value, o_out_of_range);
                mismatch_count++;
            end else begin
                want = pending_conv_q.pop_front();
                if (o_conv_value !== want.value) begin
                    $display("%0t: conv_value mismatch: expected %0d, actual %0d",
                             $time, want.value, o_conv_value);
                    mismatch_count++;
                end
                if (o_out_of_range !== want.oor) begin
                    $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                             $time, want.oor, o_out_of_range);
                    mismatch_count++;
                end
            end
        end
    end

    // Sequence
    initial begin
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_opcode     <= '0;
        i_address    <= '0;
        i_data_value <= '0;
        i_pos_x      <= '0;
        i_pos_y      <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_clamp_corners();
        test_register_floor();
        test_register_ceiling();
        test_exact_fit();
        test_mixed_sizes();
        test_back_to_back();

        wait_block_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
